// ----- hdl/gef_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gef_pkg;

	// Geometry limits of the line store.
	localparam int unsigned MaxWidth  = 1024;
	localparam int unsigned MaxHeight = 4096;
	localparam int unsigned ColW      = $clog2(MaxWidth);
	localparam int unsigned RowW      = $clog2(MaxHeight);

	// Register widths and reset values.
	localparam int unsigned ModeW   = 2;
	localparam int unsigned WidthW  = 11;
	localparam int unsigned HeightW = 13;
	localparam int unsigned CfgW    = HeightW;
	localparam int unsigned IndexW  = 2;

	localparam logic [ModeW-1:0]   ModeReset   = ModeW'(1);
	localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
	localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

	// Register indexes.
	localparam logic [IndexW-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [IndexW-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [IndexW-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// Filter modes; bit 1 alone selects the Laplacian.
	localparam logic [ModeW-1:0] MODE_PREWITT = 2'd0;
	localparam logic [ModeW-1:0] MODE_SOBEL   = 2'd1;

	// One line store entry holds the previous row and the row before it.
	typedef struct packed {
		logic [7:0] row_a;
		logic [7:0] row_b;
	} line_entry_t;

	// One column of the 3x3 window.
	typedef struct packed {
		logic [7:0] top;
		logic [7:0] mid;
		logic [7:0] bot;
	} win_col_t;

	// Window control from the pipeline to the kernel.
	typedef struct packed {
		logic             shift;
		logic [ModeW-1:0] mode;
	} win_ctrl_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} pix_word_t;

	typedef struct packed {
		logic [7:0] edge_value;
		logic       frame_last;
	} res_word_t;

	// Effective width, clamped to 3..MaxWidth.
	function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] w);
		logic [WidthW-1:0] r;
		begin
			r = w;
			if (w < WidthW'(3)) r = WidthW'(3);
			else if (w > WidthW'(MaxWidth)) r = WidthW'(MaxWidth);
			return r;
		end
	endfunction

	// Effective height, clamped to 3..MaxHeight.
	function automatic logic [HeightW-1:0] eff_height(input logic [HeightW-1:0] h);
		logic [HeightW-1:0] r;
		begin
			r = h;
			if (h < HeightW'(3)) r = HeightW'(3);
			else if (h > HeightW'(MaxHeight)) r = HeightW'(MaxHeight);
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/gef_line_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gef_line_ram (
	input  wire                        clk,
	input  wire                        rd_en,
	input  wire  [gef_pkg::ColW-1:0]   rd_addr,
	output gef_pkg::line_entry_t       rd_data,
	input  wire                        wr_en,
	input  wire  [gef_pkg::ColW-1:0]   wr_addr,
	input  wire gef_pkg::line_entry_t  wr_data
);
	import gef_pkg::*;

	line_entry_t mem_q [MaxWidth];
	line_entry_t rd_q;

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ----- hdl/gef_window.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gef_window (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire gef_pkg::win_ctrl_t ctrl,
	input  wire gef_pkg::win_col_t  col,
	output logic [7:0]              edge_value
);
	import gef_pkg::*;

	win_col_t left_q;
	win_col_t centre_q;

	logic              wide_c;
	logic [9:0]        bot_sum, top_sum, right_sum, left_sum, lap_sum;
	logic [9:0]        c_bot, c_top, c_right, c_left, c_four;
	logic signed [11:0] gx, gy, lap;
	logic [7:0]        gx_abs, gy_abs, lap_abs;
	logic [8:0]        grad_sum;

	function automatic logic [7:0] abs_sat(input logic signed [11:0] v);
		logic [11:0] m;
		begin
			m = v[11] ? 12'(-v) : 12'(v);
			return (m > 12'd255) ? 8'd255 : m[7:0];
		end
	endfunction

	// Window shifts one column each time a pixel leaves the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			centre_q <= '0;
		end else if (ctrl.shift) begin
			left_q   <= centre_q;
			centre_q <= col;
		end
	end

	// Centre weights: two for Sobel, one for Prewitt.
	always_comb begin
		wide_c  = (ctrl.mode == MODE_SOBEL);
		c_bot   = wide_c ? {1'b0, centre_q.bot, 1'b0} : {2'b00, centre_q.bot};
		c_top   = wide_c ? {1'b0, centre_q.top, 1'b0} : {2'b00, centre_q.top};
		c_right = wide_c ? {1'b0, col.mid, 1'b0}      : {2'b00, col.mid};
		c_left  = wide_c ? {1'b0, left_q.mid, 1'b0}   : {2'b00, left_q.mid};
		c_four  = {centre_q.mid, 2'b00};

		bot_sum   = {2'b00, left_q.bot} + c_bot + {2'b00, col.bot};
		top_sum   = {2'b00, left_q.top} + c_top + {2'b00, col.top};
		right_sum = {2'b00, col.top} + c_right + {2'b00, col.bot};
		left_sum  = {2'b00, left_q.top} + c_left + {2'b00, left_q.bot};
		lap_sum   = {2'b00, centre_q.top} + {2'b00, centre_q.bot}
			+ {2'b00, left_q.mid} + {2'b00, col.mid};

		gx  = $signed({2'b00, bot_sum}) - $signed({2'b00, top_sum});
		gy  = $signed({2'b00, right_sum}) - $signed({2'b00, left_sum});
		lap = $signed({2'b00, lap_sum}) - $signed({2'b00, c_four});

		gx_abs   = abs_sat(gx);
		gy_abs   = abs_sat(gy);
		lap_abs  = abs_sat(lap);
		grad_sum = {1'b0, gx_abs} + {1'b0, gy_abs};

		edge_value = ctrl.mode[1] ? lap_abs : grad_sum[8:1];
	end

endmodule

`default_nettype wire

// ----- hdl/gradient_edge_filter_3x3_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 edge filter over 8-bit grayscale pixels in raster order.
// Pixel words enter on pix_valid/pix_ready; frame_start marks row 0, column 0
// and resets the position counters. For each interior pixel one result word
// leaves on res_valid/res_ready carrying the edge strength of the pixel one row
// and one column behind the newest one; frame_last marks the final result of a
// frame. Border pixels give no result.
// Configuration (mode, width, height) is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while the block is idle, which the
// block does not enforce; index 3 is ignored. A result is registered when its
// pixel word leaves the first stage. Throughput: one pixel per clock while the
// receiver does not stall, set by the single line store memory, which is read
// at accept and written back as its word moves on, forwarding same-entry hits.
// When the receiver stalls, the output register holds its word; pixels that
// give no result still pass through, but the next one that gives a result
// waits in the first stage and the input then stalls too.
// Reset clears the counters, window and configuration to defaults; the line
// store is not cleared, as its first two rows never reach a result.
module gradient_edge_filter_3x3_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             pix_valid,
	output logic                            pix_ready,
	input  wire gef_pkg::pix_word_t         pix_word,
	output logic                            res_valid,
	input  wire                             res_ready,
	output gef_pkg::res_word_t              res_word,
	input  wire                             cfg_we,
	input  wire  [gef_pkg::IndexW-1:0]      cfg_index,
	input  wire  [gef_pkg::CfgW-1:0]        cfg_data
);
	import gef_pkg::*;

	logic [ModeW-1:0]   mode_q;
	logic [WidthW-1:0]  width_q;
	logic [HeightW-1:0] height_q;

	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;

	logic [WidthW-1:0]  w_eff;
	logic [HeightW-1:0] h_eff;
	logic [ColW-1:0]    c_cur;
	logic [RowW-1:0]    r_cur;
	logic               col_wrap, row_wrap;

	logic            pix_acc;
	logic            v_s1, emit_s1, last_s1, fwd_s1;
	logic [7:0]      pix_s1;
	logic [ColW-1:0] col_s1;
	line_entry_t     fwd_data_s1;
	logic            s1_adv;

	line_entry_t rd_data, rd_eff, wr_data;
	win_col_t    win_col;
	win_ctrl_t   win_ctrl;
	logic [7:0]  edge_s1;

	logic      res_valid_q;
	res_word_t res_word_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ModeReset;
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE:  mode_q   <= cfg_data[ModeW-1:0];
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WidthW-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the first stage frees when its word moves on.
	assign s1_adv    = v_s1 && (!emit_s1 || !res_valid_q || res_ready);
	assign pix_ready = !v_s1 || s1_adv;
	assign pix_acc   = pix_valid && pix_ready;

	// Position of the arriving pixel and the wrap of the counters.
	always_comb begin
		w_eff    = eff_width(width_q);
		h_eff    = eff_height(height_q);
		c_cur    = pix_word.frame_start ? '0 : col_q;
		r_cur    = pix_word.frame_start ? '0 : row_q;
		col_wrap = ({1'b0, c_cur} + WidthW'(1)) >= w_eff;
		row_wrap = ({1'b0, r_cur} + HeightW'(1)) >= h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : r_cur + RowW'(1);
			end else begin
				col_q <= c_cur + ColW'(1);
				row_q <= r_cur;
			end
		end
	end

	// First stage: line store read is in flight; the write-back of the word
	// leaving this stage is forwarded if the new pixel hits the same column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1      <= pix_word.pixel;
			col_s1      <= c_cur;
			emit_s1     <= (r_cur >= RowW'(2)) && (c_cur >= ColW'(2));
			last_s1     <= row_wrap && col_wrap;
			fwd_s1      <= v_s1 && (col_s1 == c_cur);
			fwd_data_s1 <= wr_data;
		end
	end

	assign rd_eff        = fwd_s1 ? fwd_data_s1 : rd_data;
	assign wr_data.row_a = pix_s1;
	assign wr_data.row_b = rd_eff.row_a;

	gef_line_ram u_line_ram (
		.clk     (clk),
		.rd_en   (pix_acc),
		.rd_addr (c_cur),
		.rd_data (rd_data),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	assign win_col.top    = rd_eff.row_b;
	assign win_col.mid    = rd_eff.row_a;
	assign win_col.bot    = pix_s1;
	assign win_ctrl.shift = s1_adv;
	assign win_ctrl.mode  = mode_q;

	gef_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (win_ctrl),
		.col        (win_col),
		.edge_value (edge_s1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			res_word_q.edge_value <= edge_s1;
			res_word_q.frame_last <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

`ifndef ASSERT_OFF
	// A pixel enters an occupied first stage only when its word moves on in the same cycle.
	a_accept_frees_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && v_s1 |-> s1_adv)
		else $error("pixel accepted over an occupied first stage");

	// A pending result must not overwrite a stalled output word.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && emit_s1 && res_valid_q && !res_ready |-> !s1_adv)
		else $error("result overwrote a stalled output word");

	// frame_start puts the counters at row 0, column 1.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && pix_word.frame_start |=> col_q == ColW'(1) && row_q == '0)
		else $error("counters wrong after frame start");

	// A new output word comes only from the first stage.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(s1_adv && emit_s1))
		else $error("output word without a source");
`endif

endmodule

`default_nettype wire

// ----- verif/gef_checker.sv -----
`timescale 1ns / 1ps

// Watches the pixel, result and register ports of the edge filter. It keeps its
// own copy of the line stores, the window and the geometry, works out the
// expected result word for each pixel word taken that gives one, and checks
// each result word against the oldest one outstanding.
module gef_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         pix_valid,
	input  wire                         pix_ready,
	input  gef_pkg::pix_word_t          pix_word,
	input  wire                         res_valid,
	input  wire                         res_ready,
	input  gef_pkg::res_word_t          res_word,
	input  wire                         cfg_we,
	input  wire  [gef_pkg::IndexW-1:0]  cfg_index,
	input  wire  [gef_pkg::CfgW-1:0]    cfg_data,
	output int unsigned                 fail_count,
	output int unsigned                 pending
);

	// Shadow state: the two previous rows, two window columns and the position.
	logic [7:0] prev_row  [gef_pkg::MaxWidth];
	logic [7:0] prev_row2 [gef_pkg::MaxWidth];
	logic [7:0] win_q [6];
	int unsigned col_pos;
	int unsigned row_pos;

	logic [gef_pkg::ModeW-1:0]   mode_q;
	logic [gef_pkg::WidthW-1:0]  width_q;
	logic [gef_pkg::HeightW-1:0] height_q;

	gef_pkg::res_word_t edge_q [$];
	gef_pkg::res_word_t oldest_word;
	int unsigned errors;

	// Magnitude of a signed sum, saturated to the 8-bit range.
	function automatic int sat_mag(input int v);
		int a;
		a = (v < 0) ? -v : v;
		return (a > 255) ? 255 : a;
	endfunction

	// Moves the window on by one pixel and queues the edge strength of the
	// pixel one row and one column behind, when that pixel is interior.
	task automatic filter_pixel(input gef_pkg::pix_word_t w);
		int unsigned wid, hgt, c, r;
		int k00, k10, k20, k01, k11, k21, k02, k12, k22;
		int wc, gx, gy, val;
		logic [7:0] top, mid;
		gef_pkg::res_word_t rw;
		wid = (width_q < 3) ? 3 : ((width_q > gef_pkg::MaxWidth) ? gef_pkg::MaxWidth : width_q);
		hgt = (height_q < 3) ? 3 :
			((height_q > gef_pkg::MaxHeight) ? gef_pkg::MaxHeight : height_q);
		if (w.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos % gef_pkg::MaxWidth;
		r = row_pos;
		top = prev_row2[c];
		mid = prev_row[c];
		if (r >= 2 && c >= 2) begin
			// Registers 0..2 hold column c-2 and 3..5 column c-1, top to bottom.
			k00 = win_q[0];
			k10 = win_q[1];
			k20 = win_q[2];
			k01 = win_q[3];
			k11 = win_q[4];
			k21 = win_q[5];
			k02 = top;
			k12 = mid;
			k22 = w.pixel;
			if (mode_q[1]) begin
				// Bit 1 of the mode selects the four-neighbour Laplacian.
				val = sat_mag(k01 + k21 + k10 + k12 - 4 * k11);
			end else begin
				wc = (mode_q == gef_pkg::MODE_SOBEL) ? 2 : 1;
				gx = sat_mag((k20 + wc * k21 + k22) - (k00 + wc * k01 + k02));
				gy = sat_mag((k02 + wc * k12 + k22) - (k00 + wc * k10 + k20));
				val = (gx + gy) >>> 1;
			end
			rw.edge_value = val[7:0];
			rw.frame_last = (r + 1 >= hgt) && (c + 1 >= wid);
			edge_q.push_back(rw);
		end
		win_q[0] = win_q[3];
		win_q[1] = win_q[4];
		win_q[2] = win_q[5];
		win_q[3] = top;
		win_q[4] = mid;
		win_q[5] = w.pixel;
		prev_row2[c] = mid;
		prev_row[c] = w.pixel;
		// A counter at or past the limit wraps, so a narrowed geometry takes hold.
		if (c + 1 >= wid) begin
			col_pos = 0;
			row_pos = (r + 1 >= hgt) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Result words are checked before the pixel of the same edge is taken in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] = 8'h00;
			col_pos = 0;
			row_pos = 0;
			mode_q = gef_pkg::ModeReset;
			width_q = gef_pkg::WidthReset;
			height_q = gef_pkg::HeightReset;
			edge_q.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (edge_q.size() == 0) begin
					errors++;
					$error("result word with nothing expected: edge_value %0d, frame_last %0d",
						res_word.edge_value, res_word.frame_last);
				end else begin
					oldest_word = edge_q.pop_front();
					if (res_word.edge_value !== oldest_word.edge_value) begin
						errors++;
						$error("edge_value: expected %0d, got %0d",
							oldest_word.edge_value, res_word.edge_value);
					end
					if (res_word.frame_last !== oldest_word.frame_last) begin
						errors++;
						$error("frame_last: expected %0d, got %0d",
							oldest_word.frame_last, res_word.frame_last);
					end
				end
			end
			if (pix_valid && pix_ready) filter_pixel(pix_word);
			if (cfg_we) begin
				case (cfg_index)
					gef_pkg::REG_FILTER_MODE:  mode_q = cfg_data[gef_pkg::ModeW-1:0];
					gef_pkg::REG_IMAGE_WIDTH:  width_q = cfg_data[gef_pkg::WidthW-1:0];
					gef_pkg::REG_IMAGE_HEIGHT: height_q = cfg_data[gef_pkg::HeightW-1:0];
					default: ;
				endcase
			end
			pending <= edge_q.size();
			fail_count <= errors;
		end
	end

endmodule

// ----- verif/tb_gradient_edge_filter_3x3_core.sv -----
`timescale 1ns / 1ps

// Drives pixel words and register writes into the edge filter, stalls the
// result side at random and gives the verdict from the checker's error count.
module tb_gradient_edge_filter_3x3_core;
	import gef_pkg::*;

	// The unused mode code and the unused register index.
	localparam logic [ModeW-1:0]  MODE_SPARE     = 2'd3;
	localparam logic [IndexW-1:0] REG_SPARE      = 2'd3;

	localparam int unsigned RandomItems = 1100;
	localparam int unsigned MaxGap      = 12;
	localparam int unsigned DrainCycles = 6;
	localparam int unsigned StallLimit  = 500;
	localparam int unsigned PhaseCap    = 300;

	typedef enum {PAT_CORNER, PAT_INVERSE, PAT_DIP} pattern_t;

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_ready;
	pix_word_t         pix_word;
	logic              res_valid;
	logic              res_ready;
	res_word_t         res_word;
	logic              cfg_we;
	logic [IndexW-1:0] cfg_index;
	logic [CfgW-1:0]   cfg_data;

	int unsigned fail_count;
	int unsigned pending;
	logic        quiet_pix;
	logic        quiet_res;
	int unsigned res_hold = 0;

	gradient_edge_filter_3x3_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_word  (pix_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gef_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix_word   (pix_word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// After each result word the receiver holds off for a drawn number of cycles.
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_hold = quiet_res ? 0 : $urandom_range(0, MaxGap);
			if (res_hold != 0) res_ready <= 1'b0;
		end else if (!res_ready) begin
			if (res_hold > 0) res_hold--;
			if (res_hold == 0) res_ready <= 1'b1;
		end
	end

	// The run ends if no word moves on either side for too long.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < StallLimit) begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (res_valid && res_ready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("tb_gradient_edge_filter_3x3_core: done, errors");
		$finish;
	end

	// Offers one pixel word after a drawn gap and returns at the edge that takes it.
	task automatic send_pixel(input logic [7:0] value, input logic start);
		int unsigned gap;
		gap = quiet_pix ? 0 : $urandom_range(0, MaxGap);
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_word.pixel <= value;
		pix_word.frame_start <= start;
		do @(posedge clk); while (!pix_ready);
	endtask

	// Waits until every expected word has come and the pipeline has emptied.
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Writes the registers picked in the mask back to back; the upper data bits
	// above each register's width are random.
	task automatic program_regs(input logic [ModeW-1:0] mode, input logic [WidthW-1:0] width,
		input logic [HeightW-1:0] height, input logic [3:0] which);
		logic [CfgW-1:0] data;
		if (which[REG_FILTER_MODE]) begin
			data = CfgW'($urandom);
			data[ModeW-1:0] = mode;
			cfg_we <= 1'b1;
			cfg_index <= REG_FILTER_MODE;
			cfg_data <= data;
			@(posedge clk);
		end
		if (which[REG_IMAGE_WIDTH]) begin
			data = CfgW'($urandom);
			data[WidthW-1:0] = width;
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data <= data;
			@(posedge clk);
		end
		if (which[REG_IMAGE_HEIGHT]) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data <= height;
			@(posedge clk);
		end
		if (which[REG_SPARE]) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_SPARE;
			cfg_data <= CfgW'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// One 3x3 frame of extreme values, laid out so that the kernels saturate.
	task automatic send_pattern(input pattern_t pat, input logic start);
		logic [7:0] value;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				case (pat)
					PAT_CORNER:  value = (r == 2 || c == 2) ? 8'hFF : 8'h00;
					PAT_INVERSE: value = (r == 2 || c == 2) ? 8'h00 : 8'hFF;
					default:     value = (r == 1 && c == 1) ? 8'h00 : 8'hFF;
				endcase
				send_pixel(value, start && r == 0 && c == 0);
			end
		end
	endtask

	initial begin
		int unsigned sent, cnt, frame_px, sel;
		int unsigned raw_w, raw_h, eff_w, eff_h, cur_w;
		logic [ModeW-1:0] mode;
		logic [3:0] which;
		logic fresh, marks, noise, start;
		logic [7:0] value;

		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pix_word <= '0;
		res_ready <= 1'b1;
		cfg_we <= 1'b0;
		cfg_index <= REG_FILTER_MODE;
		cfg_data <= '0;
		quiet_pix = 1'b0;
		quiet_res = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames: Sobel at full swing, with a write to the unused index.
		program_regs(MODE_SOBEL, WidthW'(3), HeightW'(3), 4'b1111);
		send_pattern(PAT_CORNER, 1'b1);
		settle();
		// Prewitt on the next frame, reached by the counters wrapping alone.
		program_regs(MODE_PREWITT, WidthW'(3), HeightW'(3), 4'b0001);
		send_pattern(PAT_INVERSE, 1'b0);
		settle();
		// The unused mode code falls back to the Laplacian; both sizes clamp to 3.
		program_regs(MODE_SPARE, WidthW'(0), HeightW'(2), 4'b0111);
		send_pattern(PAT_DIP, 1'b1);

		// Random phases: mostly whole frames of random content over small
		// geometries, with some that carry on mid-frame or scatter frame starts.
		raw_w = 0;
		raw_h = 2;
		cur_w = 3;
		sent = 0;
		while (sent < RandomItems) begin
			settle();
			mode = ModeW'($urandom_range(0, 3));
			which = 4'($urandom_range(0, 15));
			sel = $urandom_range(0, 9);
			if (which[REG_IMAGE_WIDTH]) begin
				if (sel == 0) raw_w = $urandom_range(0, 2);
				else if (sel == 1) raw_w = $urandom_range(13, 40);
				else raw_w = $urandom_range(3, 12);
			end
			sel = $urandom_range(0, 9);
			if (which[REG_IMAGE_HEIGHT]) begin
				if (sel == 0) raw_h = $urandom_range(0, 2);
				else if (sel == 1) raw_h = $urandom_range(MaxHeight, 8191);
				else raw_h = $urandom_range(3, 8);
			end
			eff_w = (raw_w < 3) ? 3 : ((raw_w > MaxWidth) ? MaxWidth : raw_w);
			eff_h = (raw_h < 3) ? 3 : ((raw_h > MaxHeight) ? MaxHeight : raw_h);
			program_regs(mode, WidthW'(raw_w), HeightW'(raw_h), which);

			// A wider row would reach line store entries never written, so a
			// widened geometry always opens a new frame; a narrower one may not.
			fresh = (eff_w > cur_w) || ($urandom_range(0, 3) != 0);
			cur_w = eff_w;
			frame_px = eff_w * eff_h;
			cnt = $urandom_range(1, 3) * frame_px;
			if (cnt > PhaseCap) cnt = PhaseCap;
			marks = 1'($urandom_range(0, 1));
			noise = ($urandom_range(0, 4) == 0);
			quiet_pix = ($urandom_range(0, 3) == 0);
			quiet_res = ($urandom_range(0, 3) == 0);

			for (int unsigned i = 0; i < cnt; i++) begin
				if (i == 0) start = fresh;
				else start = (marks && (i % frame_px == 0)) || (noise && $urandom_range(0, 31) == 0);
				if ($urandom_range(0, 3) == 0) value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else value = 8'($urandom_range(0, 255));
				send_pixel(value, start);
			end
			sent += cnt;
		end

		settle();
		if (fail_count == 0) begin
			$display("tb_gradient_edge_filter_3x3_core: done, clean");
		end else begin
			$display("tb_gradient_edge_filter_3x3_core: done, errors");
		end
		$finish;
	end

endmodule
